### rtl/core/slrc_pkg.sv
// Package for the sublist relation classifier: sizes, codes and transfer types.
`default_nettype none
package slrc_pkg;

   localparam int DEPTH        = 256;
   localparam int ELEMENT_BITS = 32;
   localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W        = $clog2(DEPTH + 1);

   localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [1:0] OP_COMPARE       = 2'd2;

   localparam logic [1:0] REL_EQUAL     = 2'd0;
   localparam logic [1:0] REL_SUBLIST   = 2'd1;
   localparam logic [1:0] REL_SUPERLIST = 2'd2;
   localparam logic [1:0] REL_UNEQUAL   = 2'd3;

   typedef struct packed {
      logic [1:0]                      operation;
      logic signed [ELEMENT_BITS-1:0] element;
   } req_type;

   typedef struct packed {
      logic [1:0] relation;
      logic       overflowed;
   } rsp_type;

   // read addresses from the scanner to both stores
   typedef struct packed {
      logic [ADDR_W-1:0] first_addr;
      logic [ADDR_W-1:0] second_addr;
   } scan_rd_type;

   // scanner status towards the top level
   typedef struct packed {
      logic    idle;
      logic    done;
      rsp_type result;
   } scan_stat_type;

endpackage
`default_nettype wire

### rtl/core/sublist_relation_classifier_core.sv
// Top level of the sublist relation classifier: list stores, lengths and result register.
`default_nettype none
// Builds two lists of signed elements, one append transfer each, in two
// registered-read RAMs of DEPTH entries, then on a compare transfer
// reports whether the lists are equal, the first is a contiguous sublist
// of the second, the second a sublist of the first, or unequal, plus a
// flag for appends dropped on a full list. A compare empties both lists.
// Appends are taken one per cycle while the scanner is idle, also while a
// result waits in the output register. A compare holds req_ready low while
// the scanner walks the start positions of the needle in the haystack,
// reading elements in order up to the first mismatch at each, and until
// its result has left the scanner; an empty needle skips the walk. A
// result leaves the scanner once the output register is empty or being
// read. Operation code 3 is accepted and ignored.
module sublist_relation_classifier_core
   import slrc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic [LEN_W-1:0]        first_len_ff, first_len_in;
   logic [LEN_W-1:0]        second_len_ff, second_len_in;
   logic                    lost_ff, lost_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    req_fire;
   logic                    first_we, second_we, start;
   logic                    take;
   logic [ELEMENT_BITS-1:0] first_q, second_q;
   scan_rd_type             rd;
   scan_stat_type           stat;

   // only take items while the scanner is free
   assign req_ready = stat.idle;
   assign req_fire  = req_valid && req_ready;

   // scanner result moves on once the output register is empty or draining
   assign take = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      lost_in       = lost_ff;
      first_we      = 1'b0;
      second_we     = 1'b0;
      start         = 1'b0;
      if (req_fire) begin
         unique case (req_data.operation)
            OP_APPEND_FIRST: begin
               if (first_len_ff == LEN_W'(DEPTH)) begin
                  lost_in = 1'b1;
               end else begin
                  first_we     = 1'b1;
                  first_len_in = first_len_ff + LEN_W'(1);
               end
            end
            OP_APPEND_SECOND: begin
               if (second_len_ff == LEN_W'(DEPTH)) begin
                  lost_in = 1'b1;
               end else begin
                  second_we     = 1'b1;
                  second_len_in = second_len_ff + LEN_W'(1);
               end
            end
            OP_COMPARE: begin
               // scanner captures lengths and flag, lists empty now
               start         = 1'b1;
               first_len_in  = '0;
               second_len_in = '0;
               lost_in       = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (stat.done && take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = stat.result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         lost_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         lost_ff       <= lost_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   slrc_ram #(
      .DATA_W (ELEMENT_BITS),
      .ADDR_W (ADDR_W)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (first_len_ff[ADDR_W-1:0]),
      .wr_data (req_data.element),
      .rd_addr (rd.first_addr),
      .rd_data (first_q)
   );

   slrc_ram #(
      .DATA_W (ELEMENT_BITS),
      .ADDR_W (ADDR_W)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (second_we),
      .wr_addr (second_len_ff[ADDR_W-1:0]),
      .wr_data (req_data.element),
      .rd_addr (rd.second_addr),
      .rd_data (second_q)
   );

   slrc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .first_len  (first_len_ff),
      .second_len (second_len_ff),
      .lost       (lost_ff),
      .take       (take),
      .first_q    (first_q),
      .second_q   (second_q),
      .rd         (rd),
      .stat       (stat)
   );

endmodule
`default_nettype wire

### rtl/core/slrc_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none
module slrc_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/core/slrc_scan.sv
// Start-position scan sequencer: walks both stores and classifies the pair.
`default_nettype none
module slrc_scan
   import slrc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [LEN_W-1:0]        first_len,
   input  wire logic [LEN_W-1:0]        second_len,
   input  wire logic                    lost,
   input  wire logic                    take,
   input  wire logic [ELEMENT_BITS-1:0] first_q,
   input  wire logic [ELEMENT_BITS-1:0] second_q,
   output scan_rd_type                  rd,
   output scan_stat_type                stat
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [LEN_W-1:0]  limit_ff, limit_in;
   logic [LEN_W-1:0]  nlen_ff, nlen_in;
   logic              hay_second_ff, hay_second_in;
   logic [1:0]        hit_ff, hit_in;
   logic              pend_ff, pend_in;
   logic              last_ff, last_in;
   rsp_type           result_ff, result_in;

   logic              hay_second;
   logic [LEN_W-1:0]  nlen, hlen;
   logic [ADDR_W-1:0] hay_addr, needle_addr;
   logic [LEN_W-1:0]  hay_sum;
   logic              mismatch;

   // shorter list is the needle; equal lengths use the second as haystack
   assign hay_second = (first_len <= second_len);
   assign nlen       = hay_second ? first_len : second_len;
   assign hlen       = hay_second ? second_len : first_len;

   assign hay_sum     = pos_ff + k_ff;
   assign hay_addr    = hay_sum[ADDR_W-1:0];
   assign needle_addr = k_ff[ADDR_W-1:0];
   assign mismatch    = (first_q != second_q);

   assign rd.first_addr  = hay_second_ff ? needle_addr : hay_addr;
   assign rd.second_addr = hay_second_ff ? hay_addr : needle_addr;

   assign stat.idle   = (state_ff == ST_IDLE);
   assign stat.done   = (state_ff == ST_DONE);
   assign stat.result = result_ff;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      limit_in      = limit_ff;
      nlen_in       = nlen_ff;
      hay_second_in = hay_second_ff;
      hit_in        = hit_ff;
      pend_in       = 1'b0;
      last_in       = last_ff;
      result_in     = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               hay_second_in        = hay_second;
               nlen_in              = nlen;
               limit_in             = hlen - nlen;
               pos_in               = '0;
               k_in                 = '0;
               result_in.overflowed = lost;
               if (first_len == second_len) begin
                  hit_in = REL_EQUAL;
               end else if (hay_second) begin
                  hit_in = REL_SUBLIST;
               end else begin
                  hit_in = REL_SUPERLIST;
               end
               if (nlen == '0) begin
                  // empty needle always matches
                  result_in.relation = (first_len == second_len) ? REL_EQUAL :
                                       (hay_second ? REL_SUBLIST : REL_SUPERLIST);
                  state_in           = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            priority if (pend_ff && mismatch) begin
               // drop in-flight read, move to next start position
               if (pos_ff == limit_ff) begin
                  result_in.relation = REL_UNEQUAL;
                  state_in           = ST_DONE;
               end else begin
                  pos_in = pos_ff + LEN_W'(1);
                  k_in   = '0;
               end
            end else if (pend_ff && last_ff) begin
               result_in.relation = hit_ff;
               state_in           = ST_DONE;
            end else if (k_ff < nlen_ff) begin
               pend_in = 1'b1;
               last_in = (k_ff == nlen_ff - LEN_W'(1));
               k_in    = k_ff + LEN_W'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      pos_ff        <= pos_in;
      k_ff          <= k_in;
      limit_ff      <= limit_in;
      nlen_ff       <= nlen_in;
      hay_second_ff <= hay_second_in;
      hit_ff        <= hit_in;
      last_ff       <= last_in;
      result_ff     <= result_in;
   end

endmodule
`default_nettype wire

### tb/sublist_relation_classifier_core_tb.sv
// Self-checking testbench for the sublist relation classifier core.
`default_nettype none
module sublist_relation_classifier_core_tb
   import slrc_pkg::*;
;

   // operation code 3 has no name in the package; the core accepts and drops it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef logic [ELEMENT_BITS-1:0] elem_type;
   typedef elem_type elem_list_type[$];

   localparam elem_type ELEM_MIN  = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
   localparam elem_type ELEM_MAX  = ~ELEM_MIN;
   localparam elem_type ELEM_ONES = '1;
   localparam elem_type ELEM_ZERO = '0;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sublist_relation_classifier_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Shadow copy of the two lists and the lost-element flag
   elem_list_type first_list;
   elem_list_type second_list;
   bit            lists_lost;
   rsp_type       pending_results[$];

   int fail_count      = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int overflow_seen   = 0;
   int relation_seen[4];
   bit steady          = 1'b0;   // no idling on either side while set
   int ready_hold      = 0;

   // ---------------------------------------------------------------------
   // Idle lengths: mostly none or short, now and then long
   // ---------------------------------------------------------------------
   function automatic int gap_length();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // true when needle sits contiguously somewhere in hay; empty needle always does
   function automatic bit holds_run(elem_list_type hay, elem_list_type needle);
      int  pos;
      int  k;
      bit  hit;
      if (needle.size() == 0) return 1'b1;
      for (pos = 0; pos + needle.size() <= hay.size(); pos++) begin
         hit = 1'b1;
         for (k = 0; k < needle.size() && hit; k++)
            if (hay[pos + k] !== needle[k]) hit = 1'b0;
         if (hit) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [1:0] relation_of(elem_list_type first_vals,
                                              elem_list_type second_vals);
      if (first_vals.size() == second_vals.size())
         return holds_run(first_vals, second_vals) ? REL_EQUAL : REL_UNEQUAL;
      if (first_vals.size() < second_vals.size())
         return holds_run(second_vals, first_vals) ? REL_SUBLIST : REL_UNEQUAL;
      return holds_run(first_vals, second_vals) ? REL_SUPERLIST : REL_UNEQUAL;
   endfunction

   task automatic apply_to_lists(input req_type item);
      rsp_type outcome;
      case (item.operation)
         OP_APPEND_FIRST: begin
            if (first_list.size() < DEPTH) first_list.push_back(item.element);
            else lists_lost = 1'b1;
         end
         OP_APPEND_SECOND: begin
            if (second_list.size() < DEPTH) second_list.push_back(item.element);
            else lists_lost = 1'b1;
         end
         OP_COMPARE: begin
            outcome.relation   = relation_of(first_list, second_list);
            outcome.overflowed = lists_lost;
            pending_results.push_back(outcome);
            first_list.delete();
            second_list.delete();
            lists_lost = 1'b0;
         end
         default: ;   // unused code: nothing changes
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Valid is only dropped for a gap or a drain, so it never toggles within one step
   task automatic send_item(input logic [1:0] op, input elem_type value);
      int      gap;
      req_type item;
      gap            = gap_length();
      item.operation = op;
      item.element   = value;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      apply_to_lists(item);
      items_sent++;
   endtask

   task automatic send_list(input logic [1:0] op, input elem_list_type vals);
      foreach (vals[k]) send_item(op, vals[k]);
   endtask

   // Sender holds off until every outstanding result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure and the scoreboard
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (steady) begin
         rsp_ready  <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 9) < 6) begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 20);
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= gap_length();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: relation %0d overflowed %0d",
                   rsp_data.relation, rsp_data.overflowed);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            relation_seen[want.relation]++;
            if (want.overflowed) overflow_seen++;
            if (rsp_data.relation !== want.relation) begin
               $error("relation: expected %0d, got %0d", want.relation, rsp_data.relation);
               fail_count++;
            end
            if (rsp_data.overflowed !== want.overflowed) begin
               $error("overflowed: expected %0d, got %0d",
                      want.overflowed, rsp_data.overflowed);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int short_length();
      return ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(7, 30);
   endfunction

   // style 0: tiny alphabet, plenty of partial matches; 1: anything; 2: extremes
   function automatic elem_type pick_value(input int style);
      case (style)
         0:       return elem_type'($urandom_range(0, 2));
         1:       return elem_type'($urandom());
         default: begin
            case ($urandom_range(0, 3))
               0:       return ELEM_MIN;
               1:       return ELEM_MAX;
               2:       return ELEM_ONES;
               default: return ELEM_ZERO;
            endcase
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Short hand-picked pairs: every relation, the element extremes, the unused code
   task automatic test_directed_relations();
      // both lists empty
      send_item(OP_COMPARE, ELEM_ZERO);
      // empty first list against a non-empty second list
      send_list(OP_APPEND_SECOND, '{ELEM_MIN, ELEM_MAX});
      send_item(OP_COMPARE, ELEM_ONES);
      // empty second list, with the unused code slipped in between
      send_item(OP_APPEND_FIRST, ELEM_ONES);
      send_item(OP_UNUSED, ELEM_MAX);
      send_item(OP_APPEND_FIRST, ELEM_ZERO);
      send_item(OP_COMPARE, ELEM_MIN);
      // equal lists built from the extremes
      send_list(OP_APPEND_FIRST, '{ELEM_MAX, ELEM_MIN, ELEM_ONES});
      send_list(OP_APPEND_SECOND, '{ELEM_MAX, ELEM_MIN, ELEM_ONES});
      send_item(OP_COMPARE, ELEM_ZERO);
      // first list found at the tail of the second
      send_list(OP_APPEND_FIRST, '{ELEM_ZERO, ELEM_ONES});
      send_list(OP_APPEND_SECOND, '{ELEM_MIN, ELEM_ZERO, ELEM_ONES});
      send_item(OP_COMPARE, ELEM_MAX);
      // same length, last element differs
      send_list(OP_APPEND_FIRST, '{elem_type'(1), elem_type'(2)});
      send_list(OP_APPEND_SECOND, '{elem_type'(1), elem_type'(3)});
      send_item(OP_COMPARE, ELEM_ZERO);
      wait_drained();
   endtask

   // Lists filled to capacity and beyond, plus one long scan
   task automatic test_capacity();
      elem_list_type fill;
      int            k;
      // first list over-filled; the second matches its last retained elements
      for (k = 0; k < DEPTH + 2; k++)
         fill.push_back(elem_type'(k) ^ {k[0], {(ELEMENT_BITS-1){1'b0}}});
      send_list(OP_APPEND_FIRST, fill);
      send_list(OP_APPEND_SECOND, '{fill[DEPTH-3], fill[DEPTH-2], fill[DEPTH-1]});
      send_item(OP_COMPARE, ELEM_ZERO);
      wait_drained();
      // second list over-filled, first empty; the flag must then clear
      send_list(OP_APPEND_SECOND, fill);
      send_item(OP_COMPARE, ELEM_ZERO);
      fill = fill[0:DEPTH-1];
      send_list(OP_APPEND_FIRST, fill);
      send_list(OP_APPEND_SECOND, fill);
      send_item(OP_COMPARE, ELEM_ONES);
      wait_drained();
      // near miss at every start: zeros ending in a one, against all zeros
      fill.delete();
      for (k = 0; k < DEPTH / 2 - 1; k++) fill.push_back(ELEM_ZERO);
      fill.push_back(elem_type'(1));
      send_list(OP_APPEND_FIRST, fill);
      fill.delete();
      for (k = 0; k < DEPTH; k++) fill.push_back(ELEM_ZERO);
      send_list(OP_APPEND_SECOND, fill);
      send_item(OP_COMPARE, ELEM_ZERO);
      wait_drained();
   endtask

   // One random pair: mostly related lists, appends interleaved, a little noise
   task automatic random_pair(input bit wide);
      elem_list_type hay;
      elem_list_type needle;
      elem_list_type first_vals;
      elem_list_type second_vals;
      int            hlen;
      int            nlen;
      int            pos;
      int            kind;
      int            style;
      int            k;
      style = $urandom_range(0, 2);
      kind  = $urandom_range(0, 4);   // equal, sub, super, near miss, unrelated
      hlen  = wide ? $urandom_range(DEPTH - 6, DEPTH + 4) : short_length();
      for (k = 0; k < hlen; k++) hay.push_back(pick_value(style));
      if (kind == 0) begin
         needle = hay;
      end else if (kind == 4) begin
         nlen = short_length();
         for (k = 0; k < nlen; k++) needle.push_back(pick_value(style));
      end else begin
         nlen = (hlen == 0) ? 0 : $urandom_range(0, hlen - 1);
         pos  = $urandom_range(0, hlen - nlen);
         for (k = 0; k < nlen; k++) needle.push_back(hay[pos + k]);
         if (kind == 3 && nlen > 0) begin
            k         = $urandom_range(0, nlen - 1);
            needle[k] = needle[k] ^ (elem_type'(1) << $urandom_range(0, ELEMENT_BITS - 1));
         end
      end
      if (kind == 2 || (kind >= 3 && $urandom_range(0, 1) == 1)) begin
         first_vals  = hay;
         second_vals = needle;
      end else begin
         first_vals  = needle;
         second_vals = hay;
      end
      while (first_vals.size() + second_vals.size() > 0) begin
         if ($urandom_range(0, 99) < 3) send_item(OP_UNUSED, elem_type'($urandom()));
         if (second_vals.size() == 0 || (first_vals.size() != 0 && $urandom_range(0, 1) == 1))
            send_item(OP_APPEND_FIRST, first_vals.pop_front());
         else
            send_item(OP_APPEND_SECOND, second_vals.pop_front());
      end
      // a missing compare lets this pair run on into the next one
      if ($urandom_range(0, 99) < 95) begin
         send_item(OP_COMPARE, elem_type'($urandom()));
      end
   endtask

   task automatic test_random_traffic();
      int pair;
      pair = 0;
      while (items_sent < 1750) begin
         steady = (pair % 40) >= 35;
         if (pair % 25 == 24) wait_drained();
         random_pair(pair % 80 == 79);
         pair++;
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_relations();
      test_capacity();
      test_random_traffic();
      wait_drained();
      repeat (50) @(posedge clock);
      $display("covered %0d transfers in, %0d results checked (%0d with lost elements)",
               items_sent, results_checked, overflow_seen);
      $display("relations seen: equal %0d, sublist %0d, superlist %0d, unequal %0d",
               relation_seen[REL_EQUAL], relation_seen[REL_SUBLIST],
               relation_seen[REL_SUPERLIST], relation_seen[REL_UNEQUAL]);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
